### hdl/sso_pkg.sv
`default_nettype none

package sso_pkg;

    // event kinds
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_TRIG = 2'd1;
    localparam logic [1:0] REQ_BYTE = 2'd2;

    // serial byte codes
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] STOP_BYTE = 8'd115;
    localparam logic [7:0] DIGIT_LO  = 8'd48;
    localparam logic [7:0] DIGIT_HI  = 8'd57;

    // digit slot codes
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;
    localparam logic [1:0] SLOT_UNUSED = 2'd3;

    // register map, selected by paddr[2]
    localparam logic REG_DEFAULT_UNITS = 1'b0;
    localparam logic REG_UNIT_SCALE    = 1'b1;

    localparam logic [7:0]  DEFAULT_UNITS_RST = 8'd5;
    localparam logic [15:0] UNIT_SCALE_RST    = 16'd1000;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic       pin_high;
    } evt_t;

    typedef struct packed {
        logic [7:0]  default_units;
        logic [15:0] unit_scale;
    } cfg_t;

    typedef struct packed {
        logic        pulse_active;
        logic [7:0]  setting_value;
        logic        remote_mode;
        logic [15:0] ticks_left;
    } res_t;

endpackage

`default_nettype wire

### hdl/sso_apb.sv
`default_nettype none

module sso_apb
    import sso_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_DEFAULT_UNITS: cfg_next.default_units = pwdata[7:0];
                REG_UNIT_SCALE:    cfg_next.unit_scale    = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_units <= DEFAULT_UNITS_RST;
            cfg_reg.unit_scale    <= UNIT_SCALE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DEFAULT_UNITS: prdata = {24'd0, cfg_reg.default_units};
            REG_UNIT_SCALE:    prdata = {16'd0, cfg_reg.unit_scale};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/sso_in_reg.sv
`default_nettype none

module sso_in_reg
    import sso_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire evt_t s_evt,
    input  wire logic take,     // core consumes the held transaction
    output logic      evt_valid,
    output evt_t      evt
);

    logic evt_valid_reg;
    logic evt_valid_next;
    evt_t evt_reg;

    assign s_ready        = !evt_valid_reg || take;
    assign evt_valid_next = (s_valid && s_ready) || (evt_valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evt_valid_reg <= 1'b0;
        end else begin
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            evt_reg <= s_evt;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

`default_nettype wire

### hdl/sso_core.sv
`default_nettype none

module sso_core
    import sso_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic evt_valid,
    input  wire evt_t evt,
    input  wire cfg_t cfg,
    output logic      take,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      res
);

    localparam int PROD_WIDTH = 24;

    logic [7:0]             partial_reg,  partial_next;
    logic [3:0]             first_reg,    first_next;
    logic [3:0]             second_reg,   second_next;
    logic [3:0]             last_reg,     last_next;
    logic [1:0]             slot_reg,     slot_next;
    logic                   remote_reg,   remote_next;
    logic [7:0]             setting_reg,  setting_next;
    logic [COUNT_WIDTH-1:0] ticks_reg,    ticks_next;
    logic                   pulse_reg,    pulse_next;
    logic                   out_valid_reg;
    res_t                   res_reg;

    logic [7:0]                        units;
    logic [PROD_WIDTH-1:0]             prod;
    logic [COUNT_WIDTH+PROD_WIDTH-1:0] prod_ext;
    logic [COUNT_WIDTH-1:0]            ticks_dec;
    logic [COUNT_WIDTH+15:0]           ticks_ext;
    logic [7:0]                        f8, s8, l8;

    assign take = evt_valid && (!out_valid_reg || m_ready);

    assign units     = remote_reg ? setting_reg : cfg.default_units;
    assign prod      = PROD_WIDTH'(units) * PROD_WIDTH'(cfg.unit_scale);
    assign prod_ext  = (COUNT_WIDTH+PROD_WIDTH)'(prod);
    assign ticks_dec = ticks_reg - COUNT_WIDTH'(1);

    always_comb begin
        partial_next = partial_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        last_next    = last_reg;
        slot_next    = slot_reg;
        remote_next  = remote_reg;
        setting_next = setting_reg;
        ticks_next   = ticks_reg;
        pulse_next   = pulse_reg;
        f8 = 8'd0;
        s8 = 8'd0;
        l8 = 8'd0;
        case (evt.req_type)
            REQ_TICK: begin
                ticks_next = ticks_dec;
                if (ticks_dec == '0) begin
                    pulse_next = 1'b0;
                end
            end
            REQ_TRIG: begin
                if (evt.pin_high) begin
                    ticks_next = prod_ext[COUNT_WIDTH-1:0];
                    pulse_next = 1'b1;
                end
            end
            REQ_BYTE: begin
                if (evt.rx_byte == CR_BYTE) begin
                    setting_next = partial_reg;
                    last_next    = 4'd0;
                    partial_next = 8'd0;
                    slot_next    = SLOT_FIRST;
                    remote_next  = 1'b1;
                end else begin
                    // non-digit bytes reuse the previous digit
                    if (evt.rx_byte inside {[DIGIT_LO:DIGIT_HI]}) begin
                        last_next = 4'(evt.rx_byte - DIGIT_LO);
                    end
                    f8 = {4'd0, first_reg};
                    s8 = {4'd0, second_reg};
                    l8 = {4'd0, last_next};
                    case (slot_reg)
                        SLOT_FIRST: begin
                            partial_next = l8;
                            first_next   = last_next;
                            slot_next    = SLOT_SECOND;
                        end
                        SLOT_SECOND: begin
                            partial_next = f8 * 8'd10 + l8;
                            second_next  = last_next;
                            slot_next    = SLOT_THIRD;
                        end
                        SLOT_THIRD: begin
                            partial_next = f8 * 8'd100 + s8 * 8'd10 + l8;
                        end
                        default: begin
                            partial_next = partial_reg;
                        end
                    endcase
                    if (evt.rx_byte == STOP_BYTE) begin
                        remote_next = 1'b0;
                    end
                end
            end
            default: begin
                pulse_next = pulse_reg;
            end
        endcase
    end

    assign ticks_ext = (COUNT_WIDTH+16)'(ticks_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg   <= 8'd0;
            first_reg     <= 4'd0;
            second_reg    <= 4'd0;
            last_reg      <= 4'd0;
            slot_reg      <= SLOT_FIRST;
            remote_reg    <= 1'b0;
            setting_reg   <= 8'd0;
            ticks_reg     <= '0;
            pulse_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                partial_reg <= partial_next;
                first_reg   <= first_next;
                second_reg  <= second_next;
                last_reg    <= last_next;
                slot_reg    <= slot_next;
                remote_reg  <= remote_next;
                setting_reg <= setting_next;
                ticks_reg   <= ticks_next;
                pulse_reg   <= pulse_next;
            end
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg.pulse_active  <= pulse_next;
            res_reg.setting_value <= setting_next;
            res_reg.remote_mode   <= remote_next;
            res_reg.ticks_left    <= ticks_ext[15:0];
        end
    end

    assign m_valid = out_valid_reg;
    assign res     = res_reg;

    // slot code three is never entered
    a_slot_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg != SLOT_UNUSED)
        else $error("digit slot reached unused code");

    a_trig_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        take && evt.req_type == REQ_TRIG && evt.pin_high |=> pulse_reg)
        else $error("trigger did not start pulse");

    a_cr_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        take && evt.req_type == REQ_BYTE && evt.rx_byte == CR_BYTE
        |=> remote_reg && slot_reg == SLOT_FIRST && partial_reg == 8'd0)
        else $error("return byte did not commit setting");

    a_res_mirrors: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> res_reg.pulse_active == pulse_reg
                 && res_reg.remote_mode == remote_reg
                 && res_reg.setting_value == setting_reg)
        else $error("result register disagrees with state");

endmodule

`default_nettype wire

### hdl/serial_set_oneshot_timer_core.sv
// Channel  | Direction | Ports                                   | Transfer
// ---------+-----------+-----------------------------------------+-----------------
// s_       | in        | req_type, rx_byte, pin_high             | s_valid & s_ready
// m_       | out       | pulse_active, setting_value,            | m_valid & m_ready
//          |           | remote_mode, ticks_left                 |
// APB      | in        | default_units @0x0, unit_scale @0x4     | psel&penable&pwrite
//
// An accepted event sits in the input register; once the core takes it, the state
// update (8x16 multiply for a load, decrement, digit build) runs and the result is
// loaded, raising m_valid; one transaction per cycle while m_ready stays high.
// Reset (aresetn low, synchronous) clears timer and digit state, default_units=5,
// unit_scale=1000. s_ready drops only when both the input and result registers
// hold data and m_ready is low.
`default_nettype none

module serial_set_oneshot_timer_core
    import sso_pkg::*;
#(
    parameter int COUNT_WIDTH = 16   // countdown register width, 8..32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // event channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_pin_high,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_pulse_active,
    output logic [7:0]       m_setting_value,
    output logic             m_remote_mode,
    output logic [15:0]      m_ticks_left,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    evt_t s_evt;
    evt_t evt;
    logic evt_valid;
    logic take;
    cfg_t cfg;
    res_t res;

    assign s_evt.req_type = s_req_type;
    assign s_evt.rx_byte  = s_rx_byte;
    assign s_evt.pin_high = s_pin_high;

    // configuration registers
    sso_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register; frees itself whenever the core takes its transaction
    sso_in_reg u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_evt     (s_evt),
        .take      (take),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    // timer and digit state with the result register
    sso_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_valid (evt_valid),
        .evt       (evt),
        .cfg       (cfg),
        .take      (take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res       (res)
    );

    assign m_pulse_active  = res.pulse_active;
    assign m_setting_value = res.setting_value;
    assign m_remote_mode   = res.remote_mode;
    assign m_ticks_left    = res.ticks_left;

endmodule

`default_nettype wire

### bench/tb_serial_set_oneshot_timer_core.sv
package timer_tb_pkg;
    import sso_pkg::*;

    // expected-result store plus a bit-true copy of the timer and digit state
    class timer_scoreboard;
        logic [7:0]  dflt_units;
        logic [15:0] scale;

        logic [7:0]  acc_value;
        logic [3:0]  dig0;
        logic [3:0]  dig1;
        logic [3:0]  dig_last;
        logic [1:0]  slot;
        logic        remote;
        logic [7:0]  setting;
        logic [15:0] count;
        logic        pulse;

        res_t        pending[$];
        int          errors;

        function new();
            dflt_units = DEFAULT_UNITS_RST;
            scale      = UNIT_SCALE_RST;
            acc_value  = '0;
            dig0       = '0;
            dig1       = '0;
            dig_last   = '0;
            slot       = SLOT_FIRST;
            remote     = 1'b0;
            setting    = '0;
            count      = '0;
            pulse      = 1'b0;
            errors     = 0;
        endfunction

        function void take_byte(logic [7:0] b);
            int acc;
            if (b == CR_BYTE) begin
                setting   = acc_value;
                dig_last  = '0;
                acc_value = '0;
                slot      = SLOT_FIRST;
                remote    = 1'b1;
                return;
            end
            // non-digits keep the previous digit but still take a slot
            if (b >= DIGIT_LO && b <= DIGIT_HI)
                dig_last = 4'(b - DIGIT_LO);
            case (slot)
                SLOT_FIRST: begin
                    acc_value = {4'b0, dig_last};
                    dig0      = dig_last;
                    slot      = SLOT_SECOND;
                end
                SLOT_SECOND: begin
                    acc       = dig0 * 10 + dig_last;
                    acc_value = 8'(acc);
                    dig1      = dig_last;
                    slot      = SLOT_THIRD;
                end
                SLOT_THIRD: begin
                    acc       = dig0 * 100 + dig1 * 10 + dig_last;
                    acc_value = 8'(acc);
                end
                default: ;
            endcase
            if (b == STOP_BYTE)
                remote = 1'b0;
        endfunction

        function void note_event(evt_t ev);
            logic [7:0]  units;
            logic [23:0] prod;
            res_t        r;
            case (ev.req_type)
                REQ_TICK: begin
                    count = count - 16'd1;
                    if (count == '0)
                        pulse = 1'b0;
                end
                REQ_TRIG: begin
                    if (ev.pin_high) begin
                        units = remote ? setting : dflt_units;
                        prod  = units * scale;
                        count = prod[15:0];
                        pulse = 1'b1;
                    end
                end
                REQ_BYTE: take_byte(ev.rx_byte);
                default: ;
            endcase
            r.pulse_active  = pulse;
            r.setting_value = setting;
            r.remote_mode   = remote;
            r.ticks_left    = count;
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            errors++;
            if (errors <= 200)
                $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        endtask

        task check_result(res_t got);
            res_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.pulse_active !== want.pulse_active)
                report_mismatch("pulse_active", got.pulse_active, want.pulse_active);
            if (got.setting_value !== want.setting_value)
                report_mismatch("setting_value", got.setting_value, want.setting_value);
            if (got.remote_mode !== want.remote_mode)
                report_mismatch("remote_mode", got.remote_mode, want.remote_mode);
            if (got.ticks_left !== want.ticks_left)
                report_mismatch("ticks_left", got.ticks_left, want.ticks_left);
        endtask
    endclass

endpackage

module tb_serial_set_oneshot_timer_core;
    import sso_pkg::*;
    import timer_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // byte addresses of the two config registers
    localparam logic [2:0] ADDR_DEFAULT_UNITS = {REG_DEFAULT_UNITS, 2'b00};
    localparam logic [2:0] ADDR_UNIT_SCALE    = {REG_UNIT_SCALE, 2'b00};
    // event kind with no meaning; the core must report state unchanged
    localparam logic [1:0] REQ_SPARE          = 2'd3;
    localparam int         PHASE_ITEMS        = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [7:0]  s_rx_byte;
    logic        s_pin_high;
    logic        m_valid;
    logic        m_ready;
    logic        m_pulse_active;
    logic [7:0]  m_setting_value;
    logic        m_remote_mode;
    logic [15:0] m_ticks_left;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    timer_scoreboard sb;
    int              items_sent;
    logic            no_stall;   // suppresses idling on both channels

    serial_set_oneshot_timer_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_rx_byte       (s_rx_byte),
        .s_pin_high      (s_pin_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pulse_active  (m_pulse_active),
        .m_setting_value (m_setting_value),
        .m_remote_mode   (m_remote_mode),
        .m_ticks_left    (m_ticks_left),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Result-side backpressure, changed on the falling edge like all stimulus.
    always @(negedge aclk) begin
        m_ready <= no_stall || ($urandom_range(0, 99) >= 18);
    end

    // Monitor: both handshakes sampled at the rising edge. An accepted event
    // transaction feeds the predictor; an accepted result transaction is
    // compared with the oldest prediction.
    always @(posedge aclk) begin
        evt_t ev;
        res_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                ev.req_type = s_req_type;
                ev.rx_byte  = s_rx_byte;
                ev.pin_high = s_pin_high;
                sb.note_event(ev);
            end
            if (m_valid && m_ready) begin
                got.pulse_active  = m_pulse_active;
                got.setting_value = m_setting_value;
                got.remote_mode   = m_remote_mode;
                got.ticks_left    = m_ticks_left;
                sb.check_result(got);
            end
        end
    end

    // Present one event transaction and hold it until accepted. Random idle
    // cycles go in front; valid is only lowered during those idle cycles, so
    // back-to-back transactions keep valid high across the edge.
    task send_event(logic [1:0] kind, logic [7:0] b, logic pin);
        @(negedge aclk);
        while (!no_stall && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_rx_byte  <= b;
        s_pin_high <= pin;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back, plus a
    // little slack for the two-stage pipe.
    task drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // APB write: setup, then access; register lands when pready
    // is seen high during access.
    task apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= $urandom;
    endtask

    // Only called with the core idle (after drain).
    task set_timing(logic [7:0] units, logic [15:0] scale);
        apb_write(ADDR_DEFAULT_UNITS, {24'b0, units});
        sb.dflt_units = units;
        apb_write(ADDR_UNIT_SCALE, {16'b0, scale});
        sb.scale = scale;
    endtask

    // A serial number: one to four digits, now and then a stray byte in
    // place of a digit, usually closed by a carriage return.
    task send_number;
        int n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_event(REQ_BYTE, 8'($urandom), 1'($urandom));
            else
                send_event(REQ_BYTE, DIGIT_LO + 8'($urandom_range(0, 9)), 1'($urandom));
        end
        if ($urandom_range(0, 99) < 85)
            send_event(REQ_BYTE, CR_BYTE, 1'($urandom));
    endtask

    // Random phase. Mostly well-formed traffic (numbers, triggers, tick
    // bursts long enough to run small counts out) with some noise: stop
    // bytes, random bytes, pin-low triggers and the spare event kind.
    task run_random(int target);
        int stop_at;
        int pick;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send_number();
            else if (pick < 37)
                send_event(REQ_TRIG, 8'($urandom), 1'b1);
            else if (pick < 42)
                send_event(REQ_TRIG, 8'($urandom), 1'b0);
            else if (pick < 45)
                send_event(REQ_BYTE, STOP_BYTE, 1'($urandom));
            else if (pick < 50)
                send_event(REQ_BYTE, 8'($urandom), 1'($urandom));
            else if (pick < 52)
                send_event(REQ_SPARE, 8'($urandom), 1'($urandom));
            else
                repeat ($urandom_range(1, 40))
                    send_event(REQ_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        sb         = new();
        items_sent = 0;
        no_stall   = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_req_type = REQ_TICK;
        s_rx_byte  = '0;
        s_pin_high = 1'b0;
        m_ready    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part, reset configuration (5 units x 1000) ----
        send_event(REQ_TICK, 8'hFF, 1'b1);             // idle tick wraps zero to all ones
        send_event(REQ_SPARE, 8'hFF, 1'b1);            // spare kind, state must hold
        send_event(REQ_TRIG, 8'h00, 1'b0);             // pin low does nothing
        send_event(REQ_TRIG, 8'h00, 1'b1);             // default load 5000
        send_event(REQ_TICK, 8'h00, 1'b0);
        send_event(REQ_BYTE, DIGIT_LO + 8'd2, 1'b0);
        send_event(REQ_BYTE, DIGIT_LO + 8'd5, 1'b0);
        send_event(REQ_BYTE, DIGIT_LO + 8'd5, 1'b0);   // 255
        send_event(REQ_BYTE, DIGIT_HI, 1'b0);          // fourth digit rebuilds, 8-bit wrap
        send_event(REQ_BYTE, CR_BYTE, 1'b0);           // commit, remote on
        send_event(REQ_TRIG, 8'h00, 1'b1);             // remote load
        send_event(REQ_BYTE, "x", 1'b0);               // non-digit reuses last digit
        send_event(REQ_BYTE, STOP_BYTE, 1'b0);         // leave remote mode
        send_event(REQ_BYTE, 8'hFF, 1'b1);
        send_event(REQ_BYTE, 8'h00, 1'b1);
        send_event(REQ_BYTE, DIGIT_LO - 8'd1, 1'b0);   // just below '0'
        send_event(REQ_BYTE, DIGIT_HI + 8'd1, 1'b0);   // just above '9'
        send_event(REQ_BYTE, CR_BYTE, 1'b0);
        send_event(REQ_BYTE, CR_BYTE, 1'b0);           // empty value commits zero
        send_event(REQ_TRIG, 8'h00, 1'b1);             // zero-length load still starts pulse
        send_event(REQ_TICK, 8'h00, 1'b0);             // wraps to all ones
        send_event(REQ_BYTE, DIGIT_LO, 1'b1);
        send_event(REQ_BYTE, STOP_BYTE, 1'b1);

        // ---- random phases over a spread of timing settings ----
        run_random(PHASE_ITEMS);
        drain();
        set_timing(8'd0, 16'd0);                       // both minimums
        run_random(PHASE_ITEMS);
        drain();
        set_timing(8'd255, 16'hFFFF);                  // both maximums, no idling
        no_stall = 1'b1;
        run_random(PHASE_ITEMS);
        drain();
        no_stall = 1'b0;
        set_timing(8'd1, 16'd1);                       // short pulses that run out
        run_random(PHASE_ITEMS);
        drain();
        set_timing(8'($urandom_range(1, 30)), 16'($urandom_range(1, 4)));
        run_random(PHASE_ITEMS);
        drain();
        set_timing(8'($urandom), 16'($urandom));
        run_random(PHASE_ITEMS);

        // ---- wind down ----
        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
